>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Map sizes, derived address widths, operation and result codes, and the
// packed transaction types of the input and output channels.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NODE_MAP_BYTES  = 64;
    localparam int BLOCK_MAP_BYTES = 512;
    localparam int BLOCKS_PER_FILE = 6;

    localparam int NODE_BITS  = NODE_MAP_BYTES * 8;
    localparam int BLOCK_BITS = BLOCK_MAP_BYTES * 8;

    // Byte address widths of the two maps.
    localparam int NODE_AW  = (NODE_MAP_BYTES > 1) ? $clog2(NODE_MAP_BYTES) : 1;
    localparam int BLOCK_AW = (BLOCK_MAP_BYTES > 1) ? $clog2(BLOCK_MAP_BYTES) : 1;

    // Scan pointers run up to the map size itself.
    localparam int NODE_PW  = $clog2(NODE_MAP_BYTES + 1);
    localparam int BLOCK_PW = $clog2(BLOCK_MAP_BYTES + 1);

    // Search bounds run up to the number of map bits.
    localparam int NODE_BW  = $clog2(NODE_BITS + 1);
    localparam int BLOCK_BW = $clog2(BLOCK_BITS + 1);

    // The clearing pass covers the larger map.
    localparam int CLR_N = (NODE_MAP_BYTES > BLOCK_MAP_BYTES) ? NODE_MAP_BYTES
                                                              : BLOCK_MAP_BYTES;
    localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    localparam int BPF_CW = $clog2(BLOCKS_PER_FILE + 1);
    localparam int BPF_IW = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;

    localparam int INODE_LIMIT_W = 10;
    localparam int DATA_LIMIT_W  = 13;
    localparam int CFG_W         = 13;
    localparam logic [INODE_LIMIT_W-1:0] INODE_LIMIT_RESET = 10'd512;
    localparam logic [DATA_LIMIT_W-1:0]  DATA_LIMIT_RESET  = 13'd4096;

    // Configuration register indexes.
    localparam logic REG_INODE_LIMIT = 1'b0;
    localparam logic REG_DATA_LIMIT  = 1'b1;

    // Operation codes.
    localparam logic [2:0] MODE_WR_NODE  = 3'd0;
    localparam logic [2:0] MODE_WR_BLOCK = 3'd1;
    localparam logic [2:0] MODE_RD_NODE  = 3'd2;
    localparam logic [2:0] MODE_RD_BLOCK = 3'd3;
    localparam logic [2:0] MODE_ALLOC    = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_NODE     = 2'd1;
    localparam logic [1:0] KIND_BLOCK    = 2'd2;
    localparam logic [1:0] KIND_NO_SPACE = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [8:0] byte_index;
        logic [7:0] byte_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] number;
        logic [7:0]  byte_out;
        logic        last;
    } out_item_t;

    // Granted numbers are reported in the low twelve bits.
    function automatic logic [11:0] num12(input logic [31:0] v);
        return v[11:0];
    endfunction

endpackage

>>> sv/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core: first-fit allocator over two free-space bitmaps
// Holds the node map and the block map in byte-wide memories, loads and reads
// back single bytes, and grants one node and a fixed number of data blocks.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | transaction
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall | in_item_t: mode, index, byte
//  out     | output    | out_valid/out_stall | out_item_t: kind, number, byte
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  After reset a clearing pass zeroes both maps while in_stall stays high. A
//  byte write or a byte read passes through S_RESP or S_RDW to its result. An
//  allocation scans one map byte per cycle through the single read port of each
//  map, first the node map and then the block map, then does a read-modify-write
//  of the node byte and of each granted block byte. A stalled output holds the
//  sequencer in any state that loads a result.
//
module bitmap_block_allocator_core
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RESP    = 4'd2;
    localparam logic [3:0] S_RDW     = 4'd3;
    localparam logic [3:0] S_NSCAN   = 4'd4;
    localparam logic [3:0] S_BSCAN   = 4'd5;
    localparam logic [3:0] S_NCOMMIT = 4'd6;
    localparam logic [3:0] S_BRD     = 4'd7;
    localparam logic [3:0] S_BWR     = 4'd8;

    logic [3:0]               state_reg, state_next;
    logic [CLR_W-1:0]         clr_reg, clr_next;
    logic [NODE_PW-1:0]       nptr_reg, nptr_next;
    logic [BLOCK_PW-1:0]      bptr_reg, bptr_next;
    logic [NODE_AW-1:0]       nchk_reg, nchk_next;
    logic [BLOCK_AW-1:0]      bchk_reg, bchk_next;
    logic                     dv_reg, dv_next;
    logic [BPF_CW-1:0]        got_reg, got_next;
    logic [BPF_IW-1:0]        k_reg, k_next;
    logic [NODE_AW+2:0]       node_reg, node_next;
    logic [7:0]               nbyte_reg, nbyte_next;
    logic [BLOCK_AW+2:0]      blk_reg [BLOCKS_PER_FILE];
    logic [BLOCK_AW+2:0]      blk_next [BLOCKS_PER_FILE];
    logic [BLOCK_AW+2:0]      col_blk [BLOCKS_PER_FILE];
    logic [BPF_CW-1:0]        col_got;
    in_item_t                 item_reg;
    out_item_t                res_reg, res_next;
    logic                     out_valid_reg;
    out_item_t                out_data_reg, out_next;
    logic                     out_load, out_free, in_fire;
    logic [INODE_LIMIT_W-1:0] inode_limit_reg;
    logic [DATA_LIMIT_W-1:0]  data_limit_reg;
    logic [NODE_BW-1:0]       nbound;
    logic [BLOCK_BW-1:0]      dbound;
    logic [7:0]               nfree, bfree;
    logic [2:0]               nlow;
    logic                     nany, nissue, bissue;
    logic [15:0]              in_idx16, item_idx16;

    // Map memories.
    logic [7:0]          node_mem [NODE_MAP_BYTES];
    logic [7:0]          block_mem [BLOCK_MAP_BYTES];
    logic [7:0]          node_rdata_reg, block_rdata_reg;
    logic                node_we, block_we;
    logic [NODE_AW-1:0]  node_waddr, node_raddr;
    logic [BLOCK_AW-1:0] block_waddr, block_raddr;
    logic [7:0]          node_wdata, block_wdata;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (block_we)
        begin
            block_mem[block_waddr] <= block_wdata;
        end
        block_rdata_reg <= block_mem[block_raddr];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_idx16   = 16'(in_data.byte_index);
    assign item_idx16 = 16'(item_reg.byte_index);

    // Search bounds: the smaller of the limit register and the map size in bits.
    always_comb
    begin
        if (32'(inode_limit_reg) < NODE_BITS)
            nbound = NODE_BW'(inode_limit_reg);
        else
            nbound = NODE_BW'(NODE_BITS);
        if (32'(data_limit_reg) < BLOCK_BITS)
            dbound = BLOCK_BW'(data_limit_reg);
        else
            dbound = BLOCK_BW'(BLOCK_BITS);
    end

    assign nissue = NODE_BW'({nptr_reg, 3'b000}) < nbound;
    assign bissue = BLOCK_BW'({bptr_reg, 3'b000}) < dbound;

    // Free bits of the byte just read that lie below the bound.
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            nfree[b] = !node_rdata_reg[b] && (NODE_BW'({nchk_reg, 3'(b)}) < nbound);
            bfree[b] = !block_rdata_reg[b] && (BLOCK_BW'({bchk_reg, 3'(b)}) < dbound);
        end
    end

    always_comb
    begin
        nlow = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (nfree[b])
                nlow = 3'(b);
        end
    end

    assign nany = |nfree;

    // Collect the lowest free block bits of this byte until the file is full.
    always_comb
    begin
        logic [BPF_CW-1:0] cnt;
        cnt     = got_reg;
        col_blk = blk_reg;
        for (int b = 0; b < 8; b++)
        begin
            if (bfree[b] && (cnt < BPF_CW'(BLOCKS_PER_FILE)))
            begin
                col_blk[cnt[BPF_IW-1:0]] = {bchk_reg, 3'(b)};
                cnt = cnt + BPF_CW'(1);
            end
        end
        col_got = cnt;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        nptr_next   = nptr_reg;
        bptr_next   = bptr_reg;
        nchk_next   = nchk_reg;
        bchk_next   = bchk_reg;
        dv_next     = dv_reg;
        got_next    = got_reg;
        k_next      = k_reg;
        node_next   = node_reg;
        nbyte_next  = nbyte_reg;
        blk_next    = blk_reg;
        res_next    = res_reg;
        out_load    = 1'b0;
        out_next    = out_data_reg;
        node_we     = 1'b0;
        node_waddr  = in_idx16[NODE_AW-1:0];
        node_wdata  = in_data.byte_in;
        node_raddr  = in_idx16[NODE_AW-1:0];
        block_we    = 1'b0;
        block_waddr = in_idx16[BLOCK_AW-1:0];
        block_wdata = in_data.byte_in;
        block_raddr = in_idx16[BLOCK_AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                node_we     = (32'(clr_reg) < NODE_MAP_BYTES);
                node_waddr  = clr_reg[NODE_AW-1:0];
                node_wdata  = 8'd0;
                block_we    = (32'(clr_reg) < BLOCK_MAP_BYTES);
                block_waddr = clr_reg[BLOCK_AW-1:0];
                block_wdata = 8'd0;
                if (clr_reg == CLR_W'(CLR_N - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + CLR_W'(1);
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.mode)
                        MODE_WR_NODE, MODE_WR_BLOCK:
                        begin
                            node_we  = (in_data.mode == MODE_WR_NODE) &&
                                       (32'(in_data.byte_index) < NODE_MAP_BYTES);
                            block_we = (in_data.mode == MODE_WR_BLOCK) &&
                                       (32'(in_data.byte_index) < BLOCK_MAP_BYTES);
                            res_next = '{kind: KIND_BYTE, number: 12'd0,
                                         byte_out: in_data.byte_in, last: 1'b1};
                            state_next = S_RESP;
                        end
                        MODE_RD_NODE, MODE_RD_BLOCK:
                        begin
                            state_next = S_RDW;
                        end
                        MODE_ALLOC:
                        begin
                            nptr_next  = '0;
                            dv_next    = 1'b0;
                            state_next = S_NSCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_next   = res_reg;
                    state_next = S_IDLE;
                end
            end

            S_RDW:
            begin
                // Hold the read address so the data stays put under a stall.
                node_raddr  = item_idx16[NODE_AW-1:0];
                block_raddr = item_idx16[BLOCK_AW-1:0];
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next = '{kind: KIND_BYTE, number: 12'd0, byte_out: 8'd0,
                                 last: 1'b1};
                    if (item_reg.mode == MODE_RD_NODE &&
                        32'(item_reg.byte_index) < NODE_MAP_BYTES)
                        out_next.byte_out = node_rdata_reg;
                    if (item_reg.mode == MODE_RD_BLOCK &&
                        32'(item_reg.byte_index) < BLOCK_MAP_BYTES)
                        out_next.byte_out = block_rdata_reg;
                    state_next = S_IDLE;
                end
            end

            S_NSCAN:
            begin
                node_raddr = nptr_reg[NODE_AW-1:0];
                if (dv_reg && nany)
                begin
                    node_next  = {nchk_reg, nlow};
                    nbyte_next = node_rdata_reg;
                    bptr_next  = '0;
                    got_next   = '0;
                    dv_next    = 1'b0;
                    state_next = S_BSCAN;
                end
                else if (!dv_reg && !nissue)
                begin
                    res_next = '{kind: KIND_NO_SPACE, number: 12'd0, byte_out: 8'd0,
                                 last: 1'b1};
                    state_next = S_RESP;
                end
                else if (nissue)
                begin
                    nptr_next = nptr_reg + NODE_PW'(1);
                    nchk_next = nptr_reg[NODE_AW-1:0];
                    dv_next   = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
            end

            S_BSCAN:
            begin
                block_raddr = bptr_reg[BLOCK_AW-1:0];
                if (dv_reg)
                begin
                    got_next = col_got;
                    blk_next = col_blk;
                end
                if (dv_reg && (col_got == BPF_CW'(BLOCKS_PER_FILE)))
                begin
                    k_next     = '0;
                    state_next = S_NCOMMIT;
                end
                else if (!dv_reg && !bissue)
                begin
                    res_next = '{kind: KIND_NO_SPACE, number: 12'd0, byte_out: 8'd0,
                                 last: 1'b1};
                    state_next = S_RESP;
                end
                else if (bissue)
                begin
                    bptr_next = bptr_reg + BLOCK_PW'(1);
                    bchk_next = bptr_reg[BLOCK_AW-1:0];
                    dv_next   = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
            end

            S_NCOMMIT:
            begin
                if (out_free)
                begin
                    node_we    = 1'b1;
                    node_waddr = node_reg[NODE_AW+2:3];
                    node_wdata = nbyte_reg | (8'h01 << node_reg[2:0]);
                    out_load   = 1'b1;
                    out_next   = '{kind: KIND_NODE, number: num12(32'(node_reg)),
                                   byte_out: 8'd0, last: 1'b0};
                    state_next = S_BRD;
                end
            end

            S_BRD:
            begin
                block_raddr = blk_reg[k_reg][BLOCK_AW+2:3];
                state_next  = S_BWR;
            end

            S_BWR:
            begin
                // Blocks in the same byte are updated one after another, so each
                // read sees the previous write.
                block_raddr = blk_reg[k_reg][BLOCK_AW+2:3];
                if (out_free)
                begin
                    block_we    = 1'b1;
                    block_waddr = blk_reg[k_reg][BLOCK_AW+2:3];
                    block_wdata = block_rdata_reg | (8'h01 << blk_reg[k_reg][2:0]);
                    out_load    = 1'b1;
                    out_next    = '{kind: KIND_BLOCK,
                                    number: num12(32'(blk_reg[k_reg])),
                                    byte_out: 8'd0,
                                    last: (k_reg == BPF_IW'(BLOCKS_PER_FILE - 1))};
                    if (k_reg == BPF_IW'(BLOCKS_PER_FILE - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_reg + BPF_IW'(1);
                        state_next = S_BRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            nptr_reg        <= '0;
            bptr_reg        <= '0;
            dv_reg          <= 1'b0;
            got_reg         <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
            inode_limit_reg <= INODE_LIMIT_RESET;
            data_limit_reg  <= DATA_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nptr_reg  <= nptr_next;
            bptr_reg  <= bptr_next;
            dv_reg    <= dv_next;
            got_reg   <= got_next;
            k_reg     <= k_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INODE_LIMIT: inode_limit_reg <= cfg_data[INODE_LIMIT_W-1:0];
                    REG_DATA_LIMIT:  data_limit_reg  <= cfg_data[DATA_LIMIT_W-1:0];
                    default:         data_limit_reg  <= data_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
        nchk_reg  <= nchk_next;
        bchk_reg  <= bchk_next;
        node_reg  <= node_next;
        nbyte_reg <= nbyte_next;
        blk_reg   <= blk_next;
        res_reg   <= res_next;
        if (out_load)
            out_data_reg <= out_next;
    end

endmodule

>>> sv/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker: port-level checks of the bitmap block allocator
// Watches the output transactions and the input handshake over time.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result must stay on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    // Byte loads and reads give exactly one result.
    a_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_BYTE |-> out_data.last)
        else $error("byte result not marked last");

    // A failed allocation is a single empty result.
    a_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_NO_SPACE
        |-> out_data.last && out_data.number == 12'd0 && out_data.byte_out == 8'd0)
        else $error("malformed no-space result");

    // A granted node is always followed by its blocks.
    a_node_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_NODE |-> !out_data.last)
        else $error("node grant marked last");

    // Every valid operation keeps the block busy in the next cycle.
    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (in_data.mode == MODE_WR_NODE || in_data.mode == MODE_WR_BLOCK ||
         in_data.mode == MODE_RD_NODE || in_data.mode == MODE_RD_BLOCK ||
         in_data.mode == MODE_ALLOC)
        |=> in_stall)
        else $error("input accepted again while an operation was pending");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);
